// ===== design/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg: shared definitions for the ordered list store
// Sizes, command codes and status codes used by the store and its checker.
// ----------------------------------------------------------------------------
package olst_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);

  localparam int CMD_W      = 3;
  localparam int POS_W      = 8;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 9;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

endpackage

// ===== design/olst_req_if.sv =====
// ----------------------------------------------------------------------------
// olst_req_if: command request channel
// Valid/ready channel carrying one list command per request.
// ----------------------------------------------------------------------------
interface olst_req_if;
  logic                         valid;
  logic                         ready;
  logic [olst_pkg::CMD_W-1:0]   cmd;
  logic [olst_pkg::POS_W-1:0]   position;
  logic [olst_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value,
                  input ready);
  modport sink (input valid, input cmd, input position, input item_value,
                output ready);
endinterface

// ===== design/olst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// olst_rsp_if: result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface olst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olst_pkg::VALUE_W-1:0]  read_value;
  logic [olst_pkg::STATUS_W-1:0] status;
  logic [olst_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, output read_value, output status,
                  output entry_total, input ready);
  modport sink (input valid, input read_value, input status,
                input entry_total, output ready);
endinterface

// ===== design/ordered_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_unit: ordered list kept as a compacted array in memory
// Each request is taken in the idle state. Append, write, clear and rejected
// commands go straight to the done state, read passes through the read state,
// and remove passes through the scan and shift states (one memory read per entry
// scanned or shifted). One request is in work at a time; the done state presents
// the result once the result channel is free, and only then is the next taken.
// Reset clears the state, the entry count and the result valid; memory is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_store_unit (
  input  logic     clk,
  input  logic     rst,
  olst_req_if.sink   req,
  olst_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [olst_pkg::COUNT_W-1:0] count, count_next;
  logic [olst_pkg::ADDR_W-1:0]  idx, idx_next;
  logic [olst_pkg::DATA_WIDTH-1:0] match_value, match_value_next;
  logic [olst_pkg::VALUE_W-1:0]  res_value, res_value_next;
  logic [olst_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [olst_pkg::DATA_WIDTH-1:0] mem [olst_pkg::DEPTH];
  logic                            mem_we;
  logic [olst_pkg::ADDR_W-1:0]     mem_waddr;
  logic [olst_pkg::DATA_WIDTH-1:0] mem_wdata;
  logic                            mem_re;
  logic [olst_pkg::ADDR_W-1:0]     mem_raddr;
  logic [olst_pkg::DATA_WIDTH-1:0] mem_rdata;

  logic [olst_pkg::COUNT_W-1:0] pos_ext;
  logic [olst_pkg::COUNT_W-1:0] idx_plus1;
  logic [olst_pkg::COUNT_W-1:0] idx_plus2;
  logic                         out_free;

  assign pos_ext   = olst_pkg::COUNT_W'(req.position);
  assign idx_plus1 = olst_pkg::COUNT_W'(idx) + olst_pkg::COUNT_W'(1);
  assign idx_plus2 = olst_pkg::COUNT_W'(idx) + olst_pkg::COUNT_W'(2);
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    idx_next         = idx;
    match_value_next = match_value;
    res_value_next   = res_value;
    res_status_next  = res_status;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = match_value;
    mem_re    = 1'b0;
    mem_raddr = idx;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          res_value_next   = '0;
          res_status_next  = olst_pkg::ST_OK;
          match_value_next = olst_pkg::DATA_WIDTH'(req.item_value);
          state_next       = S_DONE;
          case (req.cmd)
            olst_pkg::CMD_APPEND: begin
              if (count == olst_pkg::COUNT_FULL) begin
                res_status_next = olst_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = olst_pkg::ADDR_W'(count);
                mem_wdata  = olst_pkg::DATA_WIDTH'(req.item_value);
                count_next = count + olst_pkg::COUNT_W'(1);
              end
            end
            olst_pkg::CMD_READ: begin
              if (pos_ext >= count) begin
                res_status_next = olst_pkg::ST_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = olst_pkg::ADDR_W'(req.position);
                state_next = S_READ;
              end
            end
            olst_pkg::CMD_WRITE: begin
              if (pos_ext >= count) begin
                res_status_next = olst_pkg::ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = olst_pkg::ADDR_W'(req.position);
                mem_wdata = olst_pkg::DATA_WIDTH'(req.item_value);
              end
            end
            olst_pkg::CMD_REMOVE: begin
              if (count == '0) begin
                res_status_next = olst_pkg::ST_MISSING;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            olst_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_value_next = olst_pkg::VALUE_W'(mem_rdata);
        state_next     = S_DONE;
      end
      S_SCAN: begin
        // mem_rdata holds the entry at idx; the next read is issued at once.
        if (mem_rdata == match_value) begin
          if (idx_plus1 < count) begin
            mem_re     = 1'b1;
            mem_raddr  = olst_pkg::ADDR_W'(idx_plus1);
            state_next = S_SHIFT;
          end else begin
            count_next = count - olst_pkg::COUNT_W'(1);
            state_next = S_DONE;
          end
        end else if (idx_plus1 < count) begin
          mem_re    = 1'b1;
          mem_raddr = olst_pkg::ADDR_W'(idx_plus1);
          idx_next  = olst_pkg::ADDR_W'(idx_plus1);
        end else begin
          res_status_next = olst_pkg::ST_MISSING;
          state_next      = S_DONE;
        end
      end
      S_SHIFT: begin
        // mem_rdata holds the entry at idx + 1, which moves down to idx.
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        if (idx_plus2 < count) begin
          mem_re    = 1'b1;
          mem_raddr = olst_pkg::ADDR_W'(idx_plus2);
          idx_next  = olst_pkg::ADDR_W'(idx_plus1);
        end else begin
          count_next = count - olst_pkg::COUNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    match_value <= match_value_next;
    res_value   <= res_value_next;
    res_status  <= res_status_next;
    if (state == S_DONE && out_free) begin
      rsp.read_value  <= res_value;
      rsp.status      <= res_status;
      rsp.entry_total <= olst_pkg::TOTAL_W'(count);
    end
  end

endmodule

// ===== design/olst_chk.sv =====
// ----------------------------------------------------------------------------
// olst_chk: port checker for the ordered list store
// Watches the result channel and flags inconsistent results.
// ----------------------------------------------------------------------------
module olst_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [olst_pkg::VALUE_W-1:0]  read_value,
  input logic [olst_pkg::STATUS_W-1:0] status,
  input logic [olst_pkg::TOTAL_W-1:0]  entry_total
);

  // A stalled result must not change under the receiver.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value)
      && $stable(status) && $stable(entry_total))
    else $error("result changed while stalled");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_total <= olst_pkg::TOTAL_W'(olst_pkg::DEPTH))
    else $error("entry total beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == olst_pkg::ST_FULL
      |-> entry_total == olst_pkg::TOTAL_W'(olst_pkg::DEPTH))
    else $error("full status with list not full");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != olst_pkg::ST_OK |-> read_value == '0)
    else $error("read value on a failed command");

  // Nothing is in work right after reset, so no result may follow it.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result after reset");

endmodule

bind ordered_list_store_unit olst_chk u_olst_chk (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .read_value  (rsp.read_value),
  .status      (rsp.status),
  .entry_total (rsp.entry_total)
);

// ===== tb/ordered_list_store_unit_test.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_unit_test: self-checking bench for the ordered list store
// Sends append, read, write, remove, clear and unused commands through the
// request channel, tracks the list in a local copy, and compares every result
// with the predicted read value, status and entry total.
// ----------------------------------------------------------------------------
module ordered_list_store_unit_test;
  import olst_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = DEPTH + 16;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  entry_total;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  olst_req_if req_bus ();
  olst_rsp_if rsp_bus ();

  ordered_list_store_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #5 clk = ~clk;

  // Local copy of the list, updated as each request is accepted.
  logic [VALUE_W-1:0] list_entries [DEPTH];
  logic [COUNT_W-1:0] list_count;

  list_result_t predicted_results[$];
  bit  idle_on;
  int  fail_count;
  int  requests_sent;
  int  results_seen;
  int  full_hits;
  int  removals_done;
  int  stall_left;
  int  quiet_cycles;

  function automatic list_result_t predict_list_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [VALUE_W-1:0] value);
    list_result_t r;
    int hit;
    r.read_value = '0;
    r.status     = ST_OK;
    hit          = -1;
    case (cmd)
      CMD_APPEND: begin
        if (list_count >= COUNT_FULL) begin
          r.status = ST_FULL;
        end else begin
          list_entries[ADDR_W'(list_count)] = value;
          list_count = list_count + 1'b1;
        end
      end
      CMD_READ: begin
        if (COUNT_W'(pos) >= list_count) r.status = ST_RANGE;
        else r.read_value = list_entries[pos];
      end
      CMD_WRITE: begin
        if (COUNT_W'(pos) >= list_count) r.status = ST_RANGE;
        else list_entries[pos] = value;
      end
      CMD_REMOVE: begin
        for (int i = 0; i < list_count; i++) begin
          if (hit < 0 && list_entries[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          for (int j = hit; j + 1 < list_count; j++) list_entries[j] = list_entries[j + 1];
          list_count = list_count - 1'b1;
        end
      end
      CMD_CLEAR: list_count = '0;
      default: ;
    endcase
    r.entry_total = TOTAL_W'(list_count);
    return r;
  endfunction

  // Presents one request; returns at the falling edge after it is taken, with
  // valid still high so that a following request can go out back to back.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [VALUE_W-1:0] value);
    list_result_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= cmd;
    req_bus.position   <= pos;
    req_bus.item_value <= value;
    do @(posedge clk); while (!req_bus.ready);
    r = predict_list_result(cmd, pos, value);
    predicted_results.push_back(r);
    requests_sent++;
    if (r.status == ST_FULL) full_hits++;
    if (cmd == CMD_REMOVE && r.status == ST_OK) removals_done++;
    @(negedge clk);
  endtask

  task automatic send_random_command(input int value_span, input int clear_pct);
    int pick;
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    pick = $urandom_range(0, 99);
    if (list_count != 0 && $urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, list_count - 1));
    else pos = POS_W'($urandom);
    if (value_span == 0) value = $urandom;
    else value = VALUE_W'($urandom_range(0, value_span - 1));
    if (pick < 36) begin
      cmd = CMD_APPEND;
    end else if (pick < 54) begin
      cmd = CMD_READ;
    end else if (pick < 68) begin
      cmd = CMD_WRITE;
    end else if (pick < 96 - clear_pct) begin
      cmd = CMD_REMOVE;
      // Mostly aim at a value that is held so that the shift path is exercised.
      if (list_count != 0 && $urandom_range(0, 3) != 0) begin
        value = list_entries[$urandom_range(0, list_count - 1)];
      end
    end else if (pick < 96) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end
    send_request(cmd, pos, value);
  endtask

  task automatic test_directed_cases();
    send_request(CMD_READ, 8'd0, 32'd0);
    send_request(CMD_WRITE, 8'd0, 32'hDEAD_BEEF);
    send_request(CMD_REMOVE, 8'd0, 32'd0);
    send_request(CMD_CLEAR, 8'd0, 32'd0);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      send_request(CMD_W'(c), 8'hFF, 32'hFFFF_FFFF);
    end
    send_request(CMD_APPEND, 8'hFF, 32'd0);
    send_request(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_request(CMD_APPEND, 8'd0, 32'd5);
    send_request(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
    // Two equal entries: only the lower one may go.
    send_request(CMD_REMOVE, 8'd0, 32'hFFFF_FFFF);
    send_request(CMD_READ, 8'd1, 32'd0);
    send_request(CMD_READ, 8'd2, 32'd0);
    send_request(CMD_READ, 8'd3, 32'd0);
    send_request(CMD_READ, 8'hFF, 32'd0);
    send_request(CMD_WRITE, 8'd2, 32'hA5A5_A5A5);
    send_request(CMD_WRITE, 8'd3, 32'h5A5A_5A5A);
    send_request(CMD_READ, 8'd2, 32'd0);
    send_request(CMD_REMOVE, 8'd0, 32'd0);
    send_request(CMD_REMOVE, 8'd0, 32'd99);
    send_request(CMD_CLEAR, 8'd0, 32'd0);
    send_request(CMD_READ, 8'd0, 32'd0);
  endtask

  task automatic test_full_list();
    logic [VALUE_W-1:0] absent;
    bit held;
    send_request(CMD_CLEAR, 8'd0, 32'd0);
    repeat (DEPTH) send_request(CMD_APPEND, POS_W'($urandom), $urandom);
    send_request(CMD_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_request(CMD_APPEND, 8'hFF, 32'd0);
    send_request(CMD_READ, 8'hFF, 32'd0);
    send_request(CMD_WRITE, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_READ, 8'hFF, 32'd0);
    // A value that is not held forces a scan over the whole list.
    do begin
      absent = $urandom;
      held   = 1'b0;
      for (int i = 0; i < list_count; i++) if (list_entries[i] == absent) held = 1'b1;
    end while (held);
    send_request(CMD_REMOVE, 8'd0, absent);
    send_request(CMD_REMOVE, 8'd0, list_entries[DEPTH-1]);
    send_request(CMD_READ, 8'hFF, 32'd0);
    send_request(CMD_APPEND, 8'd0, $urandom);
    send_request(CMD_REMOVE, 8'd0, list_entries[0]);
    send_request(CMD_READ, 8'd0, 32'd0);
    send_request(CMD_READ, 8'hFE, 32'd0);
  endtask

  task automatic test_duplicate_removal();
    repeat (250) send_random_command(8, 2);
  endtask

  task automatic test_random_mix();
    repeat (1050) send_random_command(0, 1);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (150) send_random_command($urandom_range(0, 1) ? 0 : 16, 1);
  endtask

  // Result side: random stalls in short bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 3);
    rsp_bus.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        $error("unexpected result: read_value %h status %0d entry_total %0d",
               rsp_bus.read_value, rsp_bus.status, rsp_bus.entry_total);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (rsp_bus.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, rsp_bus.read_value);
          fail_count++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d, actual %0d", want.entry_total,
                 rsp_bus.entry_total);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("ordered_list_store_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.cmd        = CMD_CLEAR;
    req_bus.position   = '0;
    req_bus.item_value = '0;
    list_count         = '0;
    idle_on            = 1'b1;
    fail_count         = 0;
    requests_sent      = 0;
    results_seen       = 0;
    full_hits          = 0;
    removals_done      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_full_list();
    test_duplicate_removal();
    test_random_mix();
    test_back_to_back();

    req_bus.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results.", requests_sent, results_seen);
    $display("Appends refused on a full list: %0d; entries removed by value: %0d.",
             full_hits, removals_done);
    if (fail_count == 0) begin
      $display("ordered_list_store_unit: match");
    end else begin
      $display("ordered_list_store_unit: mismatch");
    end
    $finish;
  end

endmodule
